// ----- sv/tdt_pkg.sv -----
// shared constants, request and result codes, and controller/datapath types
// for the task timer dispatch table; no dependencies
`default_nettype none

package tdt_pkg;

  localparam int NUM_SLOTS   = 16;
  localparam int EVENT_WIDTH = 32;
  localparam int IDX_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int IDLE_LIMIT  = 2;

  // request codes; values 10 to 15 are unused and acknowledged with ok low
  localparam logic [3:0] REQ_TICK         = 4'd0;
  localparam logic [3:0] REQ_SCAN         = 4'd1;
  localparam logic [3:0] REQ_CREATE_TASK  = 4'd2;
  localparam logic [3:0] REQ_CREATE_TIMER = 4'd3;
  localparam logic [3:0] REQ_DELETE       = 4'd4;
  localparam logic [3:0] REQ_START        = 4'd5;
  localparam logic [3:0] REQ_STOP         = 4'd6;
  localparam logic [3:0] REQ_SET_EVENT    = 4'd7;
  localparam logic [3:0] REQ_CLEAR_EVENT  = 4'd8;
  localparam logic [3:0] REQ_SET_BUSY     = 4'd9;

  // result kinds
  localparam logic [1:0] KIND_ACK      = 2'd0;
  localparam logic [1:0] KIND_DISPATCH = 2'd1;
  localparam logic [1:0] KIND_FINISH   = 2'd2;

  typedef struct packed {
    logic load;       // latch the accepted request
    logic scan_clr;   // restart slot counter and busy flag
    logic rd_en;      // read slot memories
    logic rd_scan;    // read address from slot counter, else from request
    logic scan_inc;
    logic exec_cmd;   // execute the latched command, load its acknowledge
    logic exec_slot;  // update visited slot, dispatch if running or due
    logic emit_fin;   // load scan finished result
  } tdt_cmd_t;

  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic disp_need;  // visited slot will dispatch
    logic scan_last;  // visited slot is the last one
  } tdt_stat_t;

endpackage

`default_nettype wire

// ----- sv/tdt_if.sv -----
// request and result channel interfaces, valid/ready with payload
// depends on tdt_pkg
`default_nettype none

interface tdt_req_if;
  import tdt_pkg::*;

  logic        valid;
  logic        ready;
  logic [3:0]  req_type;
  logic [3:0]  entry_index;
  logic        single_shot;
  logic [31:0] period;
  logic [31:0] event_bits;
  logic        busy_value;

  modport source (output valid, req_type, entry_index, single_shot, period, event_bits,
                  busy_value, input ready);
  modport sink (input valid, req_type, entry_index, single_shot, period, event_bits,
                busy_value, output ready);
endinterface

interface tdt_rsp_if;
  import tdt_pkg::*;

  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic        ok;
  logic [3:0]  dispatch_index;
  logic [31:0] events;
  logic        sleep_request;
  logic        last;

  modport source (output valid, result_kind, ok, dispatch_index, events, sleep_request,
                  last, input ready);
  modport sink (input valid, result_kind, ok, dispatch_index, events, sleep_request,
                last, output ready);
endinterface

`default_nettype wire

// ----- sv/tdt_ctrl.sv -----
// controller state machine: sequences command execution and slot scans
// depends on tdt_pkg
`default_nettype none

module tdt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  input  wire logic              req_is_scan,
  output logic                   in_ready,
  output tdt_pkg::tdt_cmd_t      cmd,
  input  wire tdt_pkg::tdt_stat_t stat
);
  import tdt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMD_RD,
    S_CMD_EX,
    S_SCAN_RD,
    S_SCAN_EX,
    S_SCAN_FIN
  } ctrl_state_t;

  ctrl_state_t state, state_next;
  logic        in_ready_next;

  always_comb begin
    state_next    = state;
    in_ready_next = in_ready;
    cmd           = '0;
    unique case (state)
      S_IDLE: begin
        in_ready_next = 1'b1;
        if (req_valid && in_ready) begin
          cmd.load      = 1'b1;
          cmd.scan_clr  = 1'b1;
          in_ready_next = 1'b0;
          state_next    = req_is_scan ? S_SCAN_RD : S_CMD_RD;
        end
      end
      S_CMD_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_CMD_EX;
      end
      S_CMD_EX: begin
        if (stat.out_free) begin
          cmd.exec_cmd  = 1'b1;
          in_ready_next = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_scan = 1'b1;
        state_next  = S_SCAN_EX;
      end
      S_SCAN_EX: begin
        // a slot that dispatches waits for room in the output register
        if (!stat.disp_need || stat.out_free) begin
          cmd.exec_slot = 1'b1;
          if (stat.scan_last) begin
            state_next = S_SCAN_FIN;
          end else begin
            cmd.scan_inc = 1'b1;
            state_next   = S_SCAN_RD;
          end
        end
      end
      S_SCAN_FIN: begin
        if (stat.out_free) begin
          cmd.emit_fin  = 1'b1;
          in_ready_next = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b0;
    end else begin
      state    <= state_next;
      in_ready <= in_ready_next;
    end
  end

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE)
    else $error("ready raised outside idle");

  a_dispatch_has_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec_slot && stat.disp_need) |-> stat.out_free)
    else $error("dispatch issued while output register full");

  a_scan_starts: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && req_valid && in_ready && req_is_scan) |=> state == S_SCAN_RD)
    else $error("accepted scan did not start reading slots");

endmodule

`default_nettype wire

// ----- sv/tdt_datapath.sv -----
// datapath: slot flags, slot memories, tick and idle counters, output register
// depends on tdt_pkg and tdt_rsp_if
`default_nettype none

module tdt_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_wr_data,
  input  wire logic [3:0]         req_type,
  input  wire logic [3:0]         entry_index,
  input  wire logic               single_shot,
  input  wire logic [31:0]        period,
  input  wire logic [31:0]        event_bits,
  input  wire logic               busy_value,
  input  wire tdt_pkg::tdt_cmd_t  cmd,
  output tdt_pkg::tdt_stat_t      stat,
  tdt_rsp_if.source               rsp
);
  import tdt_pkg::*;

  // latched request
  logic [3:0]             cmd_type;
  logic [3:0]             cmd_idx;
  logic                   cmd_shot;
  logic [31:0]            cmd_period;
  logic [EVENT_WIDTH-1:0] cmd_bits;
  logic                   cmd_busy;

  logic sleep_enable;

  logic [NUM_SLOTS-1:0] slot_valid, slot_is_timer, slot_started, slot_running;
  logic [NUM_SLOTS-1:0] slot_single_fire, slot_busy;

  logic [31:0]            period_mem   [NUM_SLOTS];
  logic [31:0]            deadline_mem [NUM_SLOTS];
  logic [EVENT_WIDTH-1:0] pending_mem  [NUM_SLOTS];

  logic [IDX_W-1:0]       scan_idx, rd_sel, rd_addr;
  logic [31:0]            rd_period, rd_deadline;
  logic [EVENT_WIDTH-1:0] rd_pending;

  logic [31:0] tick_count;
  logic [1:0]  idle_scans, idle_inc;
  logic        scan_busy, fin_wrap, fin_sleep;

  // output register
  logic        rsp_valid, rsp_ok, rsp_sleep, rsp_last;
  logic [1:0]  rsp_kind;
  logic [3:0]  rsp_idx;
  logic [31:0] rsp_events;
  logic        rsp_load;

  logic        in_range, v, is_t, due, disp;
  logic [31:0] tick_diff;
  logic        cmd_ok, tick_inc, do_create, do_delete, do_start, do_stop;
  logic        do_set, do_clr, do_busy;

  logic                   period_we, deadline_we, pending_we;
  logic [31:0]            period_wd, deadline_wd;
  logic [EVENT_WIDTH-1:0] pending_wd;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_type   <= req_type;
      cmd_idx    <= entry_index;
      cmd_shot   <= single_shot;
      cmd_period <= period;
      cmd_bits   <= event_bits[EVENT_WIDTH-1:0];
      cmd_busy   <= busy_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sleep_enable <= 1'b0;
    end else if (cfg_wr_en) begin
      sleep_enable <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
    end else if (cmd.scan_clr) begin
      scan_idx <= '0;
    end else if (cmd.scan_inc) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
  end

  assign rd_sel = cmd.rd_scan ? scan_idx : IDX_W'(cmd_idx);

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_addr     <= rd_sel;
      rd_period   <= period_mem[rd_sel];
      rd_deadline <= deadline_mem[rd_sel];
      rd_pending  <= pending_mem[rd_sel];
    end
  end

  always_ff @(posedge clk) begin
    if (period_we) begin
      period_mem[rd_addr] <= period_wd;
    end
    if (deadline_we) begin
      deadline_mem[rd_addr] <= deadline_wd;
    end
    if (pending_we) begin
      pending_mem[rd_addr] <= pending_wd;
    end
  end

  // slot view of the entry being executed
  assign in_range  = 32'(cmd_idx) < 32'(NUM_SLOTS);
  assign v         = slot_valid[rd_addr];
  assign is_t      = slot_is_timer[rd_addr];
  assign tick_diff = tick_count - rd_deadline;
  // signed wrap compare: deadline reached when the difference is not negative
  assign due       = v && is_t && slot_started[rd_addr] && !tick_diff[31];
  assign disp      = v && (slot_running[rd_addr] || due);

  assign stat.out_free  = !rsp_valid || rsp.ready;
  assign stat.disp_need = disp;
  assign stat.scan_last = scan_idx == IDX_W'(NUM_SLOTS - 1);

  always_comb begin
    cmd_ok    = 1'b0;
    tick_inc  = 1'b0;
    do_create = 1'b0;
    do_delete = 1'b0;
    do_start  = 1'b0;
    do_stop   = 1'b0;
    do_set    = 1'b0;
    do_clr    = 1'b0;
    do_busy   = 1'b0;
    case (cmd_type) inside
      REQ_TICK: begin
        cmd_ok   = 1'b1;
        tick_inc = 1'b1;
      end
      REQ_CREATE_TASK, REQ_CREATE_TIMER: begin
        if (in_range && !v) begin
          cmd_ok    = 1'b1;
          do_create = 1'b1;
        end
      end
      REQ_DELETE, REQ_START, REQ_STOP, REQ_SET_EVENT, REQ_CLEAR_EVENT, REQ_SET_BUSY: begin
        if (in_range && v) begin
          cmd_ok = 1'b1;
          case (cmd_type)
            REQ_DELETE:      do_delete = 1'b1;
            REQ_START:       do_start  = 1'b1;
            REQ_STOP:        do_stop   = 1'b1;
            REQ_SET_EVENT:   do_set    = 1'b1;
            REQ_CLEAR_EVENT: do_clr    = 1'b1;
            default:         do_busy   = 1'b1;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    period_we   = 1'b0;
    deadline_we = 1'b0;
    pending_we  = 1'b0;
    period_wd   = '0;
    deadline_wd = '0;
    pending_wd  = '0;
    if (cmd.exec_cmd) begin
      if (do_create) begin
        period_we   = 1'b1;
        deadline_we = 1'b1;
        pending_we  = 1'b1;
      end
      if (do_start) begin
        period_we   = 1'b1;
        period_wd   = cmd_period;
        deadline_we = 1'b1;
        deadline_wd = tick_count + cmd_period;
      end
      if (do_set) begin
        pending_we = 1'b1;
        pending_wd = rd_pending | cmd_bits;
      end
      if (do_clr) begin
        pending_we = 1'b1;
        pending_wd = rd_pending & ~cmd_bits;
      end
    end
    if (cmd.exec_slot) begin
      if (due) begin
        deadline_we = 1'b1;
        deadline_wd = tick_count + rd_period;
      end
      if (disp) begin
        pending_we = 1'b1;
      end
    end
  end

  assign idle_inc  = idle_scans + 2'd1;
  assign fin_wrap  = !scan_busy && (idle_inc > 2'(IDLE_LIMIT));
  assign fin_sleep = fin_wrap && sleep_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid       <= '0;
      slot_is_timer    <= '0;
      slot_started     <= '0;
      slot_running     <= '0;
      slot_single_fire <= '0;
      slot_busy        <= '0;
      tick_count       <= '0;
      idle_scans       <= '0;
      scan_busy        <= 1'b0;
    end else begin
      if (cmd.exec_cmd) begin
        if (tick_inc) begin
          tick_count <= tick_count + 32'd1;
        end
        if (do_create) begin
          slot_valid[rd_addr]       <= 1'b1;
          slot_is_timer[rd_addr]    <= cmd_type == REQ_CREATE_TIMER;
          slot_started[rd_addr]     <= cmd_type != REQ_CREATE_TIMER;
          slot_running[rd_addr]     <= cmd_type != REQ_CREATE_TIMER;
          slot_single_fire[rd_addr] <= cmd_type == REQ_CREATE_TIMER;
          slot_busy[rd_addr]        <= 1'b0;
        end
        if (do_delete) begin
          slot_valid[rd_addr] <= 1'b0;
        end
        if (do_start) begin
          slot_single_fire[rd_addr] <= cmd_shot;
          slot_started[rd_addr]     <= 1'b1;
          slot_is_timer[rd_addr]    <= 1'b1;
        end
        if (do_stop) begin
          slot_started[rd_addr] <= 1'b0;
        end
        if (do_busy) begin
          slot_busy[rd_addr] <= cmd_busy;
        end
      end
      // a due timer runs for this visit only
      if (cmd.exec_slot && disp) begin
        if (slot_single_fire[rd_addr] && is_t) begin
          slot_started[rd_addr] <= 1'b0;
        end
        slot_running[rd_addr] <= !is_t;
      end
      if (cmd.scan_clr) begin
        scan_busy <= 1'b0;
      end else if (cmd.exec_slot && disp && slot_busy[rd_addr]) begin
        scan_busy <= 1'b1;
      end
      if (cmd.emit_fin) begin
        if (scan_busy || fin_wrap) begin
          idle_scans <= '0;
        end else begin
          idle_scans <= idle_inc;
        end
      end
    end
  end

  assign rsp_load = cmd.exec_cmd || (cmd.exec_slot && disp) || cmd.emit_fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec_cmd) begin
      rsp_kind   <= KIND_ACK;
      rsp_ok     <= cmd_ok;
      rsp_idx    <= '0;
      rsp_events <= '0;
      rsp_sleep  <= 1'b0;
      rsp_last   <= 1'b1;
    end else if (cmd.exec_slot && disp) begin
      rsp_kind   <= KIND_DISPATCH;
      rsp_ok     <= 1'b1;
      rsp_idx    <= 4'(rd_addr);
      rsp_events <= 32'(rd_pending);
      rsp_sleep  <= 1'b0;
      rsp_last   <= 1'b0;
    end else if (cmd.emit_fin) begin
      rsp_kind   <= KIND_FINISH;
      rsp_ok     <= 1'b1;
      rsp_idx    <= '0;
      rsp_events <= '0;
      rsp_sleep  <= fin_sleep;
      rsp_last   <= 1'b1;
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.result_kind    = rsp_kind;
  assign rsp.ok             = rsp_ok;
  assign rsp.dispatch_index = rsp_idx;
  assign rsp.events         = rsp_events;
  assign rsp.sleep_request  = rsp_sleep;
  assign rsp.last           = rsp_last;

  a_idle_below_wrap: assert property (@(posedge clk) disable iff (rst)
    idle_scans <= 2'(IDLE_LIMIT))
    else $error("idle scan count passed its limit");

  a_load_has_room: assert property (@(posedge clk) disable iff (rst)
    rsp_load |-> (!rsp_valid || rsp.ready))
    else $error("output register overwritten before transfer");

  a_finish_is_last: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_fin |=> (rsp_valid && rsp_last && rsp_kind == KIND_FINISH))
    else $error("scan finish result not marked last");

endmodule

`default_nettype wire

// ----- sv/task_timer_dispatch_table.sv -----
// top level of the task timer dispatch table: controller plus datapath
// depends on tdt_pkg, tdt_if (request/result interfaces), tdt_ctrl, tdt_datapath
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    req_type, entry_index, single_shot, period, event_bits,
//                                busy_value
//   rsp      out  valid/ready    result_kind, ok, dispatch_index, events,
//                                sleep_request, last
//   cfg      in   cfg_wr_en      cfg_wr_data (sleep_enable)
//
// one request at a time; a command reads its slot, then executes once the output register
// has room and loads its acknowledge there
// a scan reads, then updates each slot in turn and then loads the finish result; each slot
// goes through the single read port of the slot period/deadline/pending memories
// ready returns at the edge that loads the last result into the output register
// a full output register stalls the controller at the next result; rst is synchronous

`default_nettype none

module task_timer_dispatch_table (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_wr_en,
  input  wire logic  cfg_wr_data,
  tdt_req_if.sink    req,
  tdt_rsp_if.source  rsp
);
  import tdt_pkg::*;

  tdt_cmd_t  cmd;
  tdt_stat_t stat;
  logic      in_ready;

  assign req.ready = in_ready;

  tdt_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_is_scan (req.req_type == REQ_SCAN),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .stat        (stat)
  );

  tdt_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_type    (req.req_type),
    .entry_index (req.entry_index),
    .single_shot (req.single_shot),
    .period      (req.period),
    .event_bits  (req.event_bits),
    .busy_value  (req.busy_value),
    .cmd         (cmd),
    .stat        (stat),
    .rsp         (rsp)
  );

endmodule

`default_nettype wire

// ----- verif/tdt_table_watch.sv -----
`timescale 1ns / 100ps
// checker for the task timer dispatch table: rebuilds the slot table from the
// request transfers, predicts every result and compares the result transfers
// depends on tdt_pkg and tdt_if
module tdt_table_watch
  import tdt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  tdt_req_if   req,
  tdt_rsp_if   rsp,
  output int   errors,
  output int   waiting,
  output int   dispatches,
  output int   sleeps
);

  localparam logic [31:0] EV_MASK =
    (EVENT_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << EVENT_WIDTH) - 64'd1);

  typedef struct {
    logic [1:0]  kind;
    logic        ok;
    logic [3:0]  slot;
    logic [31:0] events;
    logic        sleep;
    logic        last;
  } table_out_t;

  table_out_t due_results[$];

  // shadow of the slot table
  logic        occupied   [NUM_SLOTS];
  logic        is_timer   [NUM_SLOTS];
  logic        armed      [NUM_SLOTS];
  logic        runnable   [NUM_SLOTS];
  logic        fire_once  [NUM_SLOTS];
  logic [31:0] reload     [NUM_SLOTS];
  logic [31:0] deadline   [NUM_SLOTS];
  logic [31:0] pend_ev    [NUM_SLOTS];
  logic        busy_flag  [NUM_SLOTS];
  logic [31:0] ticks;
  logic [1:0]  idle_run;
  logic        sleep_en;

  int err_n;
  int disp_n;
  int sleep_n;

  function automatic void push_out(logic [1:0] kind, logic ok, logic [3:0] slot,
                                   logic [31:0] events, logic sleep, logic last);
    table_out_t r;
    r.kind   = kind;
    r.ok     = ok;
    r.slot   = slot;
    r.events = events;
    r.sleep  = sleep;
    r.last   = last;
    due_results.push_back(r);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_n++;
    end
  endfunction

  // one pass over the table: fire due timers, dispatch runnable entries
  task automatic run_scan();
    logic        any_busy;
    logic        slp;
    logic [31:0] diff;
    any_busy = 1'b0;
    slp      = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (occupied[i]) begin
        diff = ticks - deadline[i];
        if (is_timer[i] && armed[i] && !diff[31]) begin
          runnable[i] = 1'b1;
          deadline[i] = ticks + reload[i];
        end
        if (runnable[i]) begin
          if (fire_once[i] && is_timer[i])
            armed[i] = 1'b0;
          push_out(KIND_DISPATCH, 1'b1, 4'(i), pend_ev[i], 1'b0, 1'b0);
          pend_ev[i] = '0;
          if (busy_flag[i])
            any_busy = 1'b1;
          if (is_timer[i])
            runnable[i] = 1'b0;
        end
      end
    end
    if (!any_busy) begin
      idle_run = idle_run + 2'd1;
      if (idle_run > IDLE_LIMIT) begin
        idle_run = '0;
        slp      = sleep_en;
      end
    end else begin
      idle_run = '0;
    end
    push_out(KIND_FINISH, 1'b1, '0, '0, slp, 1'b1);
  endtask

  task automatic apply_request(logic [3:0] rq, logic [3:0] ix, logic shot,
                               logic [31:0] per, logic [31:0] bits, logic bval);
    logic good;
    logic in_table;
    int   s;
    good     = 1'b0;
    in_table = int'(ix) < NUM_SLOTS;
    s        = in_table ? int'(ix) : 0;
    bits     = bits & EV_MASK;
    if (rq == REQ_SCAN) begin
      run_scan();
    end else begin
      case (rq)
        REQ_TICK: begin
          ticks = ticks + 32'd1;
          good  = 1'b1;
        end
        REQ_CREATE_TASK, REQ_CREATE_TIMER: begin
          if (in_table && !occupied[s]) begin
            occupied[s]  = 1'b1;
            is_timer[s]  = (rq == REQ_CREATE_TIMER);
            armed[s]     = (rq == REQ_CREATE_TASK);
            runnable[s]  = (rq == REQ_CREATE_TASK);
            fire_once[s] = (rq == REQ_CREATE_TIMER);
            reload[s]    = '0;
            deadline[s]  = '0;
            pend_ev[s]   = '0;
            busy_flag[s] = 1'b0;
            good         = 1'b1;
          end
        end
        REQ_DELETE, REQ_START, REQ_STOP, REQ_SET_EVENT, REQ_CLEAR_EVENT, REQ_SET_BUSY: begin
          if (in_table && occupied[s]) begin
            good = 1'b1;
            case (rq)
              REQ_DELETE: occupied[s] = 1'b0;
              REQ_START: begin
                // a start on a task turns it into a timer
                reload[s]    = per;
                fire_once[s] = shot;
                armed[s]     = 1'b1;
                deadline[s]  = ticks + per;
                is_timer[s]  = 1'b1;
              end
              REQ_STOP:        armed[s] = 1'b0;
              REQ_SET_EVENT:   pend_ev[s] = pend_ev[s] | bits;
              REQ_CLEAR_EVENT: pend_ev[s] = pend_ev[s] & ~bits;
              default:         busy_flag[s] = bval;
            endcase
          end
        end
        default: ;
      endcase
      push_out(KIND_ACK, good, '0, '0, 1'b0, 1'b1);
    end
  endtask

  always @(posedge clk) begin
    table_out_t want;
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        occupied[i]  = 1'b0;
        is_timer[i]  = 1'b0;
        armed[i]     = 1'b0;
        runnable[i]  = 1'b0;
        fire_once[i] = 1'b0;
        reload[i]    = '0;
        deadline[i]  = '0;
        pend_ev[i]   = '0;
        busy_flag[i] = 1'b0;
      end
      ticks    = '0;
      idle_run = '0;
      sleep_en = 1'b0;
      due_results.delete();
    end else begin
      if (cfg_wr_en)
        sleep_en = cfg_wr_data;
      if (rsp.valid && rsp.ready) begin
        if (due_results.size() == 0) begin
          $error("result transfer with nothing outstanding: kind %0d slot %0d",
                 rsp.result_kind, rsp.dispatch_index);
          err_n++;
        end else begin
          want = due_results.pop_front();
          check_field("result_kind", 32'(want.kind), 32'(rsp.result_kind));
          check_field("ok", 32'(want.ok), 32'(rsp.ok));
          check_field("dispatch_index", 32'(want.slot), 32'(rsp.dispatch_index));
          check_field("events", want.events, rsp.events);
          check_field("sleep_request", 32'(want.sleep), 32'(rsp.sleep_request));
          check_field("last", 32'(want.last), 32'(rsp.last));
          if (want.kind == KIND_DISPATCH)
            disp_n++;
          if (want.kind == KIND_FINISH && want.sleep)
            sleep_n++;
        end
      end
      if (req.valid && req.ready)
        apply_request(req.req_type, req.entry_index, req.single_shot, req.period,
                      req.event_bits, req.busy_value);
    end
    errors     <= err_n;
    waiting    <= due_results.size();
    dispatches <= disp_n;
    sleeps     <= sleep_n;
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// top of the dispatch table testbench: clock, reset, request stimulus, result
// stalls and the verdict; depends on tdt_pkg, tdt_if, task_timer_dispatch_table and tdt_table_watch
module testbench;
  import tdt_pkg::*;

  localparam int          QUIET_LIMIT      = 2000;
  localparam logic [3:0]  REQ_FIRST_UNUSED = 4'd10;
  localparam logic [3:0]  REQ_LAST_UNUSED  = 4'd15;

  typedef enum int {RSP_OPEN, RSP_RANDOM, RSP_PATTERN} rsp_mode_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  slot;
    logic        shot;
    logic [31:0] period;
    logic [31:0] bits;
    logic        busy;
  } request_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      cfg_wr_en;
  logic      cfg_wr_data;
  rsp_mode_t rsp_mode = RSP_RANDOM;
  int        sent;
  int        quiet;
  int        errors;
  int        waiting;
  int        dispatches;
  int        sleeps;

  tdt_req_if req ();
  tdt_rsp_if rsp ();

  task_timer_dispatch_table dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req),
    .rsp         (rsp)
  );

  tdt_table_watch watch (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req),
    .rsp         (rsp),
    .errors      (errors),
    .waiting     (waiting),
    .dispatches  (dispatches),
    .sleeps      (sleeps)
  );

  always #2 clk = ~clk;

  // result side stalls
  initial begin
    int stall_left;
    int cyc;
    stall_left = 0;
    cyc        = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      case (rsp_mode)
        RSP_OPEN:    rsp.ready <= 1'b1;
        RSP_PATTERN: rsp.ready <= (cyc % 7) < 4;
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            rsp.ready <= 1'b0;
          end else if ($urandom_range(99) < 25) begin
            stall_left = $urandom_range(20);
            rsp.ready <= 1'b0;
          end else begin
            rsp.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic request_t make_request(logic [3:0] kind, logic [3:0] slot, logic shot,
                                            logic [31:0] period, logic [31:0] bits,
                                            logic busy);
    request_t r;
    r.kind   = kind;
    r.slot   = slot;
    r.shot   = shot;
    r.period = period;
    r.bits   = bits;
    r.busy   = busy;
    return r;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 18)      r.kind = REQ_TICK;
    else if (pick < 38) r.kind = REQ_SCAN;
    else if (pick < 46) r.kind = REQ_CREATE_TASK;
    else if (pick < 54) r.kind = REQ_CREATE_TIMER;
    else if (pick < 59) r.kind = REQ_DELETE;
    else if (pick < 70) r.kind = REQ_START;
    else if (pick < 74) r.kind = REQ_STOP;
    else if (pick < 84) r.kind = REQ_SET_EVENT;
    else if (pick < 89) r.kind = REQ_CLEAR_EVENT;
    else if (pick < 97) r.kind = REQ_SET_BUSY;
    else                r.kind = REQ_FIRST_UNUSED + 4'($urandom_range(5));
    // favor the low slots so commands keep hitting live entries
    r.slot = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(7));
    r.shot = 1'($urandom_range(1));
    case ($urandom_range(9))
      0, 1, 2, 3, 4: r.period = 32'($urandom_range(4));
      5:             r.period = 32'h8000_0000 - 32'($urandom_range(2));
      6:             r.period = 32'hFFFF_FFFF - 32'($urandom_range(2));
      default:       r.period = $urandom;
    endcase
    case ($urandom_range(7))
      0:          r.bits = '0;
      1:          r.bits = 32'hFFFF_FFFF;
      2, 3, 4:    r.bits = 32'd1 << $urandom_range(31);
      default:    r.bits = $urandom;
    endcase
    r.busy = ($urandom_range(9) < 3);
    return r;
  endfunction

  task automatic send_request(request_t r);
    req.valid       <= 1'b1;
    req.req_type    <= r.kind;
    req.entry_index <= r.slot;
    req.single_shot <= r.shot;
    req.period      <= r.period;
    req.event_bits  <= r.bits;
    req.busy_value  <= r.busy;
    do @(posedge clk); while (!req.ready);
    sent++;
  endtask

  task automatic run_random(int count, bit with_gaps);
    int burst;
    int gap;
    burst = $urandom_range(1, 12);
    for (int k = 0; k < count; k++) begin
      send_request(random_request());
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        gap   = with_gaps ? $urandom_range(6) : 0;
        if (gap > 0) begin
          req.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    req.valid <= 1'b0;
  endtask

  // hold the sender until every predicted result has been transferred
  task automatic wait_drained();
    do @(posedge clk); while (waiting != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_sleep_enable(logic value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    request_t plan[$];
    rst             <= 1'b1;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= 1'b0;
    req.valid       <= 1'b0;
    req.req_type    <= REQ_TICK;
    req.entry_index <= '0;
    req.single_shot <= 1'b0;
    req.period      <= '0;
    req.event_bits  <= '0;
    req.busy_value  <= 1'b0;
    sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_sleep_enable(1'b1);

    plan.push_back(make_request(REQ_SCAN, 4'd0, 1'b0, '0, '0, 1'b0));
    plan.push_back(make_request(REQ_TICK, 4'd0, 1'b0, '0, '0, 1'b0));
    plan.push_back(make_request(REQ_CREATE_TASK, 4'd0, 1'b0, '0, '0, 1'b0));
    // create on an occupied slot, delete on a free one
    plan.push_back(make_request(REQ_CREATE_TASK, 4'd0, 1'b0, '0, '0, 1'b0));
    plan.push_back(make_request(REQ_CREATE_TIMER, 4'd15, 1'b0, '0, '0, 1'b0));
    plan.push_back(make_request(REQ_DELETE, 4'd7, 1'b0, '0, '0, 1'b0));
    plan.push_back(make_request(REQ_SET_EVENT, 4'd0, 1'b0, '0, 32'hFFFF_FFFF, 1'b0));
    plan.push_back(make_request(REQ_CLEAR_EVENT, 4'd0, 1'b0, '0, 32'h5555_5555, 1'b0));
    plan.push_back(make_request(REQ_SET_BUSY, 4'd0, 1'b0, '0, '0, 1'b1));
    plan.push_back(make_request(REQ_SCAN, 4'd0, 1'b0, '0, '0, 1'b0));
    plan.push_back(make_request(REQ_START, 4'd15, 1'b1, 32'd0, '0, 1'b0));
    plan.push_back(make_request(REQ_SCAN, 4'd0, 1'b0, '0, '0, 1'b0));
    // start on a task turns it into a periodic timer already due
    plan.push_back(make_request(REQ_START, 4'd0, 1'b0, 32'hFFFF_FFFF, '0, 1'b0));
    plan.push_back(make_request(REQ_SCAN, 4'd0, 1'b0, '0, '0, 1'b0));
    plan.push_back(make_request(REQ_STOP, 4'd0, 1'b0, '0, '0, 1'b0));
    plan.push_back(make_request(REQ_SET_BUSY, 4'd0, 1'b0, '0, '0, 1'b0));
    // three idle scans reach the sleep limit
    plan.push_back(make_request(REQ_SCAN, 4'd0, 1'b0, '0, '0, 1'b0));
    plan.push_back(make_request(REQ_SCAN, 4'd0, 1'b0, '0, '0, 1'b0));
    plan.push_back(make_request(REQ_SCAN, 4'd0, 1'b0, '0, '0, 1'b0));
    plan.push_back(make_request(REQ_LAST_UNUSED, 4'd3, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                1'b1));
    plan.push_back(make_request(REQ_DELETE, 4'd15, 1'b0, '0, '0, 1'b0));
    plan.push_back(make_request(REQ_START, 4'd15, 1'b0, 32'd5, '0, 1'b0));
    plan.push_back(make_request(REQ_START, 4'd0, 1'b0, 32'h8000_0000, '0, 1'b0));
    plan.push_back(make_request(REQ_TICK, 4'd0, 1'b0, '0, '0, 1'b0));
    plan.push_back(make_request(REQ_SCAN, 4'd0, 1'b0, '0, '0, 1'b0));
    foreach (plan[k])
      send_request(plan[k]);
    req.valid <= 1'b0;
    wait_drained();

    write_sleep_enable(1'b0);
    rsp_mode = RSP_OPEN;
    run_random(100, 1'b0);
    wait_drained();

    write_sleep_enable(1'b1);
    rsp_mode = RSP_RANDOM;
    run_random(70, 1'b1);
    wait_drained();
    run_random(70, 1'b1);
    wait_drained();

    write_sleep_enable(1'b0);
    rsp_mode = RSP_PATTERN;
    run_random(120, 1'b1);
    wait_drained();

    write_sleep_enable(1'b1);
    rsp_mode = RSP_RANDOM;
    run_random(120, 1'b1);
    wait_drained();
    repeat (40) @(posedge clk);

    $display("summary: %0d requests sent, %0d dispatches and %0d sleep requests checked",
             sent, dispatches, sleeps);
    $display("summary: sleep enable exercised at 0 and 1, open, random and patterned stalls");
    if (errors == 0 && waiting == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

// ----- task_timer_dispatch_table.f -----
sv/tdt_pkg.sv
sv/tdt_if.sv
sv/tdt_ctrl.sv
sv/tdt_datapath.sv
sv/task_timer_dispatch_table.sv
verif/tdt_table_watch.sv
verif/testbench.sv
